>>> hw/rtl/bbmg_pkg.sv
// bbmg_pkg: shared types and constants of the vertical-byte bitmap blit mask generator
// used by bbmg_cfg, bbmg_geom, bbmg_core and the top level; depends on nothing

package bbmg_pkg;

  localparam int unsigned MAX_SCREEN_WIDTH  = 512;
  localparam int unsigned MAX_SCREEN_HEIGHT = 256;

  localparam int unsigned DstW   = 14;
  localparam int unsigned SrcW   = 18;
  localparam int unsigned ColW   = 10;
  localparam int unsigned RowW   = 6;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  // register index, taken from paddr[4:2]
  typedef enum logic [2:0] {
    REG_POS_X          = 3'd0,
    REG_POS_Y          = 3'd1,
    REG_BLIT_WIDTH     = 3'd2,
    REG_BLIT_HEIGHT    = 3'd3,
    REG_SRC_ROW_STRIDE = 3'd4,
    REG_SCREEN_WIDTH   = 3'd5,
    REG_SCREEN_HEIGHT  = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [10:0] pos_x;
    logic [10:0] pos_y;
    logic [9:0]  blit_width;
    logic [9:0]  blit_height;
    logic [11:0] src_row_stride;
    logic [9:0]  screen_width;
    logic [8:0]  screen_height;
  } cfg_t;

  // clipped blit geometry
  typedef struct packed {
    logic            active;
    logic [2:0]      shift;
    logic [ColW-1:0] ncols;
    logic [RowW-1:0] nrows;
    logic [RowW-1:0] nreads;
    logic [7:0]      top;
    logic [7:0]      bottom;
    logic [DstW-1:0] start;
    logic [9:0]      sw;
  } geom_t;

  typedef struct packed {
    logic [DstW-1:0] dst_offset;
    logic [7:0]      bit_mask;
    logic [7:0]      pixel_bits;
    logic [SrcW-1:0] next_src_offset;
    logic            column_end;
    logic            last;
  } res_t;

endpackage

>>> hw/rtl/bbmg_cfg.sv
// bbmg_cfg: APB-style register file holding the blit configuration
// depends on bbmg_pkg; any write to a listed register pulses restart

module bbmg_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bbmg_pkg::AddrW-1:0] paddr,
  input  logic [bbmg_pkg::DataW-1:0] pwdata,
  output logic [bbmg_pkg::DataW-1:0] prdata,
  output logic                       pready,
  output bbmg_pkg::cfg_t             cfg_o,
  output logic                       restart_o
);
  import bbmg_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;
  logic     hit;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    hit   = 1'b1;
    case (idx)
      REG_POS_X:          cfg_d.pos_x          = pwdata[10:0];
      REG_POS_Y:          cfg_d.pos_y          = pwdata[10:0];
      REG_BLIT_WIDTH:     cfg_d.blit_width     = pwdata[9:0];
      REG_BLIT_HEIGHT:    cfg_d.blit_height    = pwdata[9:0];
      REG_SRC_ROW_STRIDE: cfg_d.src_row_stride = pwdata[11:0];
      REG_SCREEN_WIDTH:   cfg_d.screen_width   = pwdata[9:0];
      REG_SCREEN_HEIGHT:  cfg_d.screen_height  = pwdata[8:0];
      default:            hit                  = 1'b0;
    endcase
  end

  always_comb begin
    case (idx)
      REG_POS_X:          prdata = {21'd0, cfg_q.pos_x};
      REG_POS_Y:          prdata = {21'd0, cfg_q.pos_y};
      REG_BLIT_WIDTH:     prdata = {22'd0, cfg_q.blit_width};
      REG_BLIT_HEIGHT:    prdata = {22'd0, cfg_q.blit_height};
      REG_SRC_ROW_STRIDE: prdata = {20'd0, cfg_q.src_row_stride};
      REG_SCREEN_WIDTH:   prdata = {22'd0, cfg_q.screen_width};
      REG_SCREEN_HEIGHT:  prdata = {23'd0, cfg_q.screen_height};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pos_x          <= 11'd0;
      cfg_q.pos_y          <= 11'd0;
      cfg_q.blit_width     <= 10'd0;
      cfg_q.blit_height    <= 10'd1;
      cfg_q.src_row_stride <= 12'd1;
      cfg_q.screen_width   <= 10'd128;
      cfg_q.screen_height  <= 9'd64;
    end else if (wr_en) begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o     = cfg_q;
  assign restart_o = wr_en & hit;

endmodule

>>> hw/rtl/bbmg_geom.sv
// bbmg_geom: clips the blit rectangle to the screen and registers the geometry
// depends on bbmg_pkg; fed from the register file every cycle

module bbmg_geom (
  input  logic           clk_i,
  input  bbmg_pkg::cfg_t cfg_i,
  output bbmg_pkg::geom_t geom_o
);
  import bbmg_pkg::*;

  localparam logic [9:0] SwMax = 10'(MAX_SCREEN_WIDTH);
  localparam logic [8:0] ShMax = 9'(MAX_SCREEN_HEIGHT);

  geom_t       geom_d, geom_q;
  logic [9:0]  sw;
  logic [8:0]  sh;
  logic        off_scr;
  logic [8:0]  ux;
  logic [7:0]  uy;
  logic [10:0] sum_x, sum_y;
  logic [9:0]  nx, ny;
  logic [10:0] tot, tot_m1, nr_sum;
  logic [14:0] row_base;
  logic [7:0]  top, bot;

  always_comb begin
    sw = (cfg_i.screen_width > SwMax) ? SwMax : cfg_i.screen_width;
    sh = (cfg_i.screen_height > ShMax) ? ShMax : cfg_i.screen_height;

    off_scr = cfg_i.pos_x[10] | cfg_i.pos_y[10] | (cfg_i.pos_x[9:0] >= sw)
            | (cfg_i.pos_y[9:0] >= {1'b0, sh});
    ux = cfg_i.pos_x[8:0];
    uy = cfg_i.pos_y[7:0];

    sum_x = {2'b0, ux} + {1'b0, cfg_i.blit_width};
    nx    = (sum_x >= {1'b0, sw}) ? (sw - {1'b0, ux}) : cfg_i.blit_width;
    sum_y = {3'b0, uy} + {1'b0, cfg_i.blit_height};
    ny    = (sum_y >= {2'b0, sh}) ? ({1'b0, sh} - {2'b0, uy}) : cfg_i.blit_height;

    tot    = {1'b0, ny} + {8'd0, uy[2:0]};
    tot_m1 = tot - 11'd1;
    nr_sum = {1'b0, ny} + 11'd7;

    top = 8'hFF << uy[2:0];
    bot = ~(8'hFE << tot_m1[2:0]);
    // a single byte row takes both edges
    if (tot <= 11'd8) begin
      bot = bot & top;
    end

    row_base = {5'd0, sw} * {10'd0, uy[7:3]};

    geom_d.active = ~off_scr & (nx != 10'd0) & (ny != 10'd0);
    geom_d.shift  = uy[2:0];
    geom_d.ncols  = nx;
    geom_d.nrows  = tot_m1[8:3] + 6'd1;
    geom_d.nreads = nr_sum[8:3];
    geom_d.top    = top;
    geom_d.bottom = bot;
    geom_d.start  = row_base[DstW-1:0] + {5'd0, ux};
    geom_d.sw     = sw;
  end

  always_ff @(posedge clk_i) begin
    geom_q <= geom_d;
  end

  assign geom_o = geom_q;

endmodule

>>> hw/rtl/bbmg_core.sv
// bbmg_core: input register, blit walk state, shift/mask logic and result register
// depends on bbmg_pkg; geometry comes from bbmg_geom, restart from bbmg_cfg

module bbmg_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bbmg_pkg::geom_t geom_i,
  input  logic [11:0]     stride_i,
  input  logic            restart_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      source_byte_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output bbmg_pkg::res_t  res_o
);
  import bbmg_pkg::*;

  function automatic logic [7:0] row_mask(geom_t g, logic [RowW-1:0] row);
    logic [RowW:0] row_p1;
    row_p1 = {1'b0, row} + {{RowW{1'b0}}, 1'b1};
    if (row_p1 >= {1'b0, g.nrows}) begin
      return g.bottom;
    end else if (row == '0) begin
      return g.top;
    end else begin
      return 8'hFF;
    end
  endfunction

  // input stage
  logic       s1_v_q;
  logic [7:0] s1_byte_q;

  // walk state
  logic [7:0]      carry_q, carry_d;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [DstW-1:0] dst_q, dst_d;
  logic [SrcW-1:0] src_q, src_d;
  logic            fin_q, fin_d;
  logic            fresh_q;

  // result stage: head slot plus a second slot for the carry-only write
  logic  o_v_q, x_v_q;
  res_t  o_q, x_q;
  res_t  r0, r1;
  logic  extra;

  logic            work, drop, fire, room, out_take;
  logic [15:0]     shifted;
  logic [7:0]      comb_bits;
  logic [DstW-1:0] dst_cur, dst_nxt_row;
  logic [SrcW-1:0] nsrc_row, nsrc_col;
  logic [ColW-1:0] col_p1;
  logic [RowW-1:0] row_p1;
  logic            col_done, last_col;

  assign out_take = o_v_q & ~out_stall_i;
  assign room     = ~o_v_q | (out_take & ~x_v_q);
  assign work     = s1_v_q & geom_i.active & ~fin_q;
  assign drop     = s1_v_q & ~work;
  assign fire     = work & room;
  assign in_stall_o = s1_v_q & ~(drop | fire);

  always_comb begin
    shifted     = {8'd0, s1_byte_q} << geom_i.shift;
    comb_bits   = carry_q | shifted[7:0];
    dst_cur     = fresh_q ? geom_i.start : dst_q;
    dst_nxt_row = dst_cur + {4'd0, geom_i.sw};
    nsrc_row    = src_q + {6'd0, stride_i};
    col_p1      = col_q + 10'd1;
    row_p1      = row_q + 6'd1;
    col_done    = (row_p1 >= geom_i.nreads);
    last_col    = ({1'b0, col_q} + 11'd1) >= {1'b0, geom_i.ncols};
    nsrc_col    = last_col ? '0 : {8'd0, col_p1};
    extra       = col_done & (row_p1 < geom_i.nrows);

    r0.dst_offset      = dst_cur;
    r0.bit_mask        = row_mask(geom_i, row_q);
    r0.pixel_bits      = comb_bits;
    r0.next_src_offset = col_done ? nsrc_col : nsrc_row;
    r0.column_end      = col_done & ~extra;
    r0.last            = col_done & ~extra & last_col;

    r1.dst_offset      = dst_nxt_row;
    r1.bit_mask        = row_mask(geom_i, row_p1);
    r1.pixel_bits      = shifted[15:8];
    r1.next_src_offset = nsrc_col;
    r1.column_end      = 1'b1;
    r1.last            = last_col;

    carry_d = carry_q;
    col_d   = col_q;
    row_d   = row_q;
    dst_d   = dst_cur;
    src_d   = src_q;
    fin_d   = fin_q;
    if (col_done) begin
      carry_d = '0;
      col_d   = col_p1;
      row_d   = '0;
      dst_d   = geom_i.start + {4'd0, col_p1};
      src_d   = nsrc_col;
      fin_d   = last_col;
    end else begin
      carry_d = shifted[15:8];
      row_d   = row_p1;
      dst_d   = dst_nxt_row;
      src_d   = nsrc_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      s1_byte_q <= source_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= '0;
      col_q   <= '0;
      row_q   <= '0;
      dst_q   <= '0;
      src_q   <= '0;
      fin_q   <= 1'b0;
      fresh_q <= 1'b1;
    end else if (restart_i) begin
      carry_q <= '0;
      col_q   <= '0;
      row_q   <= '0;
      dst_q   <= '0;
      src_q   <= '0;
      fin_q   <= 1'b0;
      fresh_q <= 1'b1;
    end else if (fire) begin
      carry_q <= carry_d;
      col_q   <= col_d;
      row_q   <= row_d;
      dst_q   <= dst_d;
      src_q   <= src_d;
      fin_q   <= fin_d;
      fresh_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
      x_v_q <= 1'b0;
    end else if (fire) begin
      o_v_q <= 1'b1;
      x_v_q <= extra;
    end else if (out_take) begin
      o_v_q <= x_v_q;
      x_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      o_q <= r0;
      x_q <= r1;
    end else if (out_take && x_v_q) begin
      o_q <= x_q;
    end
  end

  assign out_valid_o = o_v_q;
  assign res_o       = o_q;

endmodule

>>> hw/rtl/bitmap_blit_mask_generator.sv
// bitmap_blit_mask_generator: top level of the vertical-byte bitmap blit mask generator
// depends on bbmg_pkg, bbmg_cfg, bbmg_geom and bbmg_core
//
//   channel   direction  handshake                        payload
//   in        sink       in_valid_i / in_stall_o          source_byte_i
//   out       source     out_valid_o / out_stall_i        dst_offset_o .. last_o
//   apb       slave      psel, penable, pwrite, pready    paddr, pwdata, prdata
//
// one source byte per cycle unless out_stall_i backs up; a byte that closes a column
// with a carry-only write yields two results and stalls the input for the second.
// a result passes the input register, then the result register; a register write
// lands in the register file first and in the geometry register after it.
// rst_ni clears walk state, loads register reset values; a write to a listed register
// restarts the blit. out_stall_i backs up through the result slots into in_stall_o.

module bitmap_blit_mask_generator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bbmg_pkg::AddrW-1:0] paddr,
  input  logic [bbmg_pkg::DataW-1:0] pwdata,
  output logic [bbmg_pkg::DataW-1:0] prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 source_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [bbmg_pkg::DstW-1:0]  dst_offset_o,
  output logic [7:0]                 bit_mask_o,
  output logic [7:0]                 pixel_bits_o,
  output logic [bbmg_pkg::SrcW-1:0]  next_src_offset_o,
  output logic                       column_end_o,
  output logic                       last_o
);
  import bbmg_pkg::*;

  cfg_t  cfg;
  geom_t geom;
  res_t  res;
  logic  restart;

  bbmg_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg_o     (cfg),
    .restart_o (restart)
  );

  bbmg_geom u_geom (
    .clk_i  (clk_i),
    .cfg_i  (cfg),
    .geom_o (geom)
  );

  bbmg_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .geom_i        (geom),
    .stride_i      (cfg.src_row_stride),
    .restart_i     (restart),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .source_byte_i (source_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .res_o         (res)
  );

  assign dst_offset_o      = res.dst_offset;
  assign bit_mask_o        = res.bit_mask;
  assign pixel_bits_o      = res.pixel_bits;
  assign next_src_offset_o = res.next_src_offset;
  assign column_end_o      = res.column_end;
  assign last_o            = res.last;

endmodule
